// ===== sv/ultrasonic_range_beam_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic range and beam controller
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_BEAM_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_RANGE_BEAM_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define URBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/urbc_pkg.sv =====
// ----------------------------------------------------------------------------
// urbc_pkg
// Shared types, constants and helpers of the ultrasonic range beam controller.
// ----------------------------------------------------------------------------
package urbc_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TRIG_W     = 16;
  localparam int EDGE_CM_W  = 10;
  localparam int EDGE_W     = 20;   // edge in cm times 1000
  localparam int DUTY_W     = 7;
  localparam int WIDTH_OUT_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [EDGE_W-1:0] EDGE_SCALE = EDGE_W'(1000);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(100);

  localparam logic [TRIG_W-1:0] TRIG_LEN_RST   = TRIG_W'(1000);
  localparam logic [EDGE_W-1:0] FAR_EDGE_RST   = EDGE_W'(20000);
  localparam logic [EDGE_W-1:0] MID_EDGE_RST   = EDGE_W'(15000);
  localparam logic [EDGE_W-1:0] NEAR_EDGE_RST  = EDGE_W'(10000);
  localparam logic [EDGE_W-1:0] CLOSE_EDGE_RST = EDGE_W'(5000);
  localparam logic [DUTY_W-1:0] LOW_DUTY_RST   = DUTY_W'(10);
  localparam logic [DUTY_W-1:0] HIGH_DUTY_RST  = DUTY_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_LEN   = 3'd0,
    CFG_FAR_EDGE   = 3'd1,
    CFG_MID_EDGE   = 3'd2,
    CFG_NEAR_EDGE  = 3'd3,
    CFG_CLOSE_EDGE = 3'd4,
    CFG_LOW_DUTY   = 3'd5,
    CFG_HIGH_DUTY  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_TIME    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    LM_OFF  = 2'd0,
    LM_LOW  = 2'd1,
    LM_AUTO = 2'd2
  } lamp_mode_t;

  typedef enum logic [2:0] {
    BAND_NONE  = 3'd0,
    BAND_FAR   = 3'd1,
    BAND_MID   = 3'd2,
    BAND_NEAR  = 3'd3,
    BAND_CLOSE = 3'd4,
    BAND_MIN   = 3'd5
  } band_t;

  // edges kept pre-scaled, duties kept capped at 100
  typedef struct packed {
    logic [TRIG_W-1:0] trig_len;
    logic [EDGE_W-1:0] far_edge;
    logic [EDGE_W-1:0] mid_edge;
    logic [EDGE_W-1:0] near_edge;
    logic [EDGE_W-1:0] close_edge;
    logic [DUTY_W-1:0] low_duty;
    logic [DUTY_W-1:0] high_duty;
  } cfg_t;

  typedef struct packed {
    logic                   trigger_out;
    logic [DUTY_W-1:0]      lamp_duty;
    logic                   warn_led;
    lamp_mode_t             lamp_mode;
    band_t                  range_band;
    logic [WIDTH_OUT_W-1:0] echo_width;
    logic                   new_reading;
  } res_t;

  function automatic logic [DUTY_W-1:0] band_duty(input band_t b);
    logic [DUTY_W-1:0] d;
    unique case (b)
      BAND_FAR:   d = DUTY_W'(100);
      BAND_MID:   d = DUTY_W'(80);
      BAND_NEAR:  d = DUTY_W'(60);
      BAND_CLOSE: d = DUTY_W'(40);
      BAND_MIN:   d = DUTY_W'(20);
      default:    d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [DUTY_W-1:0] cap_duty(input logic [DUTY_W-1:0] v);
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

endpackage

// ===== sv/urbc_cfg.sv =====
// ----------------------------------------------------------------------------
// urbc_cfg
// Configuration register file; scales edges to cm*1000 and caps duties on write.
// ----------------------------------------------------------------------------
module urbc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [urbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output urbc_pkg::cfg_t                  cfg
);

  urbc_pkg::cfg_t cfg_r;
  urbc_pkg::cfg_t cfg_nxt;
  logic [urbc_pkg::EDGE_W-1:0] edge_scaled;
  logic [urbc_pkg::DUTY_W-1:0] duty_capped;

  assign edge_scaled = urbc_pkg::EDGE_W'(cfg_wdata[urbc_pkg::EDGE_CM_W-1:0])
                       * urbc_pkg::EDGE_SCALE;
  assign duty_capped = urbc_pkg::cap_duty(cfg_wdata[urbc_pkg::DUTY_W-1:0]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (urbc_pkg::cfg_idx_t'(cfg_index))
        urbc_pkg::CFG_TRIG_LEN:   cfg_nxt.trig_len   = cfg_wdata[urbc_pkg::TRIG_W-1:0];
        urbc_pkg::CFG_FAR_EDGE:   cfg_nxt.far_edge   = edge_scaled;
        urbc_pkg::CFG_MID_EDGE:   cfg_nxt.mid_edge   = edge_scaled;
        urbc_pkg::CFG_NEAR_EDGE:  cfg_nxt.near_edge  = edge_scaled;
        urbc_pkg::CFG_CLOSE_EDGE: cfg_nxt.close_edge = edge_scaled;
        urbc_pkg::CFG_LOW_DUTY:   cfg_nxt.low_duty   = duty_capped;
        urbc_pkg::CFG_HIGH_DUTY:  cfg_nxt.high_duty  = duty_capped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_len   <= urbc_pkg::TRIG_LEN_RST;
      cfg_r.far_edge   <= urbc_pkg::FAR_EDGE_RST;
      cfg_r.mid_edge   <= urbc_pkg::MID_EDGE_RST;
      cfg_r.near_edge  <= urbc_pkg::NEAR_EDGE_RST;
      cfg_r.close_edge <= urbc_pkg::CLOSE_EDGE_RST;
      cfg_r.low_duty   <= urbc_pkg::LOW_DUTY_RST;
      cfg_r.high_duty  <= urbc_pkg::HIGH_DUTY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/urbc_step.sv =====
// ----------------------------------------------------------------------------
// urbc_step
// Measurement state machine, band classifier and lamp logic for one event.
// ----------------------------------------------------------------------------
module urbc_step #(
  parameter int COUNT_BITS = urbc_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           cmd,
  input  logic           echo,
  input  urbc_pkg::cfg_t cfg,
  output urbc_pkg::res_t res
);

  localparam int LW = (COUNT_BITS > urbc_pkg::TRIG_W) ? COUNT_BITS : urbc_pkg::TRIG_W;
  localparam int DW = (COUNT_BITS + 5 > urbc_pkg::EDGE_W) ? COUNT_BITS + 5
                                                          : urbc_pkg::EDGE_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  urbc_pkg::phase_t     phase_r, phase_nxt;
  urbc_pkg::lamp_mode_t mode_r, mode_nxt;
  urbc_pkg::band_t      band_r, band_nxt, band_cls;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [COUNT_BITS-1:0] width_r, width_nxt;
  logic                  led_r, led_nxt;
  logic                  fresh;
  logic                  trig_done;
  logic [urbc_pkg::TRIG_W-1:0] trig_len;
  logic [DW-1:0]         dist_milli, f_e, m_e, n_e, c_e;
  logic [LW-1:0]         width_ext;

  assign cnt_inc  = (cnt_r == CMAX) ? cnt_r : cnt_r + 1'b1;
  assign trig_len = (cfg.trig_len == '0) ? urbc_pkg::TRIG_W'(1) : cfg.trig_len;
  assign trig_done = (LW'(cnt_inc) >= LW'(trig_len)) || (cnt_inc == CMAX);

  // distance*1000 = width*17
  assign dist_milli = (DW'(cnt_r) << 4) + DW'(cnt_r);
  assign f_e  = DW'(cfg.far_edge);
  assign m_e  = DW'(cfg.mid_edge);
  assign n_e  = DW'(cfg.near_edge);
  assign c_e  = DW'(cfg.close_edge);

  // on-edge or misordered edges fall through and keep the old band
  always_comb begin
    priority if (dist_milli > f_e)                      band_cls = urbc_pkg::BAND_FAR;
    else if (dist_milli > m_e && dist_milli < f_e)      band_cls = urbc_pkg::BAND_MID;
    else if (dist_milli > n_e && dist_milli < m_e)      band_cls = urbc_pkg::BAND_NEAR;
    else if (dist_milli > c_e && dist_milli < n_e)      band_cls = urbc_pkg::BAND_CLOSE;
    else if (dist_milli < c_e)                          band_cls = urbc_pkg::BAND_MIN;
    else                                                band_cls = band_r;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    band_nxt  = band_r;
    mode_nxt  = mode_r;
    if (cmd) begin
      unique case (mode_r)
        urbc_pkg::LM_OFF: mode_nxt = urbc_pkg::LM_LOW;
        urbc_pkg::LM_LOW: mode_nxt = urbc_pkg::LM_AUTO;
        default:          mode_nxt = urbc_pkg::LM_OFF;
      endcase
    end else begin
      unique case (phase_r)
        urbc_pkg::PH_WAIT: begin
          if (echo) begin
            phase_nxt = urbc_pkg::PH_TIME;
            cnt_nxt   = COUNT_BITS'(1);
          end
        end
        urbc_pkg::PH_TIME: begin
          if (echo) begin
            cnt_nxt = cnt_inc;
          end else begin
            width_nxt = cnt_r;
            band_nxt  = band_cls;
            phase_nxt = urbc_pkg::PH_TRIGGER;
            cnt_nxt   = '0;
          end
        end
        default: begin
          if (trig_done) begin
            phase_nxt = urbc_pkg::PH_WAIT;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      endcase
    end
  end

  assign fresh = !cmd && (phase_r == urbc_pkg::PH_TIME) && !echo;
  assign width_ext = LW'(width_nxt);

  // outputs
  always_comb begin
    led_nxt = led_r;
    res.lamp_duty = '0;
    if (mode_nxt == urbc_pkg::LM_LOW) begin
      res.lamp_duty = cfg.low_duty;
    end else if (mode_nxt == urbc_pkg::LM_AUTO) begin
      res.lamp_duty = (band_nxt == urbc_pkg::BAND_NONE) ? cfg.high_duty
                                                        : urbc_pkg::band_duty(band_nxt);
      if (band_nxt == urbc_pkg::BAND_FAR || band_nxt == urbc_pkg::BAND_MID ||
          band_nxt == urbc_pkg::BAND_NEAR) begin
        led_nxt = 1'b0;
      end else if (band_nxt == urbc_pkg::BAND_MIN) begin
        led_nxt = 1'b1;
      end
    end
    res.trigger_out = (phase_r == urbc_pkg::PH_TRIGGER);
    res.warn_led    = led_nxt;
    res.lamp_mode   = mode_nxt;
    res.range_band  = band_nxt;
    res.echo_width  = (width_ext > LW'(16'hFFFF)) ? 16'hFFFF
                                                  : width_ext[urbc_pkg::WIDTH_OUT_W-1:0];
    res.new_reading = fresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urbc_pkg::PH_TRIGGER;
      cnt_r   <= '0;
      width_r <= '0;
      band_r  <= urbc_pkg::BAND_NONE;
      mode_r  <= urbc_pkg::LM_OFF;
      led_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      band_r  <= band_nxt;
      mode_r  <= mode_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

// ===== sv/ultrasonic_range_beam_controller.sv =====
// A request's result is offered once the request has passed the input
// register and then the result register.
// Throughput: one request per cycle; the input register refills while the
// result register is taken, so the stream only stalls on out_tready.
// Reset: synchronous, active-low rst_n restores register defaults, trigger
// phase, cleared counters, band none and lamp off.
// ----------------------------------------------------------------------------
// ultrasonic_range_beam_controller
// Ultrasonic ranger with trigger timing, echo width, distance bands and lamp.
// ----------------------------------------------------------------------------
module ultrasonic_range_beam_controller #(
  parameter int COUNT_BITS = urbc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [urbc_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] echo_level, rest zero
  input  logic                            in_tuser,   // [0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] trigger_out, [7:1] lamp_duty, [8] warn_led, [10:9] lamp_mode,
  // [13:11] range_band, [29:14] echo_width, [30] new_reading, [31] zero
  output logic [urbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [urbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "ultrasonic_range_beam_controller_assert.svh"

  urbc_pkg::cfg_t cfg;
  urbc_pkg::res_t res;

  logic in_valid_r, in_valid_nxt;
  logic in_cmd_r, in_echo_r;
  logic out_valid_r, out_valid_nxt;
  logic [urbc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  urbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  urbc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cmd   (in_cmd_r),
    .echo  (in_echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_echo_r <= in_tdata[0];
    end
    if (adv) begin
      out_data_r <= {1'b0, res.new_reading, res.echo_width, res.range_band,
                     res.lamp_mode, res.warn_led, res.lamp_duty, res.trigger_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a held request is never dropped before it is processed
  `URBC_ASSERT_NEXT(a_in_hold, in_valid_r && !adv, in_valid_r, "input request lost")
  // every processed request leaves a result behind
  `URBC_ASSERT_NEXT(a_res_load, adv, out_valid_r, "result not loaded")
  // a finished measurement never coincides with the trigger phase
  `URBC_ASSERT_SAME(a_fresh_trig, out_valid_r && out_data_r[30], !out_data_r[0],
                    "new reading during trigger")
  // lamp off means zero duty
  `URBC_ASSERT_SAME(a_off_duty, out_valid_r && out_data_r[10:9] == 2'd0,
                    out_data_r[7:1] == 7'd0, "duty nonzero with lamp off")

endmodule
